// ===== rtl/core/pt4m_pkg.sv =====
// Shared types, constants and helpers for the pT/eta/phi to four-momentum block.
package pt4m_pkg;

    // Fixed-point fractions are Q30
    localparam int          FRAC_BITS  = 30;
    localparam logic [31:0] PI_Q30     = 32'd3373259426;
    localparam logic [29:0] LN2_Q30    = 30'd744261118;
    localparam logic [30:0] Q_ONE      = 31'h4000_0000;

    // Series lengths
    localparam int TRIG_TERMS = 14;
    localparam int EXP_TERMS  = 16;

    // Largest ln2 multiple contained in |eta|
    localparam int N_MAX = 11;

    // Accumulator update codes of a series cell
    localparam int OP_NONE = 0;
    localparam int OP_ADD  = 1;
    localparam int OP_SUB  = 2;

    // Series accumulator
    typedef logic signed [32:0] t_acc;

    // Per-particle data that rides alongside the series chains
    typedef struct packed {
        logic [15:0] pt;
        logic [1:0]  quad;
        logic        swap;
        logic        neg;
        logic [3:0]  n;
    } t_side;

    // k * ln2 in Q30
    function automatic logic [35:0] ln2_mult(input logic [3:0] k);
        ln2_mult = 36'(k) * 36'(LN2_Q30);
    endfunction

endpackage

// ===== rtl/core/pt4m_delay.sv =====
// Enable-gated register delay line for payload words.
module pt4m_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_pipe [DEPTH];

    // shift one place per advancing cycle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe[0] <= i_d;
            for (int i = 1; i < DEPTH; i++) begin
                r_pipe[i] <= r_pipe[i-1];
            end
        end
    end

    assign o_q = r_pipe[DEPTH-1];

endmodule

// ===== rtl/core/pt4m_series_cell.sv =====
// One Taylor-series cell: term_k = ((term_{k-1} * arg) >> 30) / K, then accumulate.
module pt4m_series_cell #(
    parameter int K    = 1,
    parameter int A_OP = 1,
    parameter int B_OP = 0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [30:0]          i_term,
    input  logic [29:0]          i_arg,
    input  pt4m_pkg::t_acc       i_acc_a,
    input  pt4m_pkg::t_acc       i_acc_b,
    output logic [30:0]          o_term,
    output logic [29:0]          o_arg,
    output pt4m_pkg::t_acc       o_acc_a,
    output pt4m_pkg::t_acc       o_acc_b
);
    import pt4m_pkg::*;

    // exact floor(q / K) for q < 2^30 by round-up reciprocal
    localparam int          L  = $clog2(K);
    localparam int          SH = FRAC_BITS + L;
    localparam logic [31:0] M  = 32'(((64'd1 << SH) + 64'(K) - 64'd1) / 64'(K));

    logic [60:0] r_p1;
    logic [29:0] r_arg1;
    t_acc        r_acc_a1;
    t_acc        r_acc_b1;
    logic [61:0] r_p2;
    logic [29:0] r_arg2;
    t_acc        r_acc_a2;
    t_acc        r_acc_b2;
    logic [30:0] w_term;
    t_acc        w_term_s;

    // stage A: term * arg; stage B: quotient by reciprocal
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1     <= 61'(i_term) * 61'(i_arg);
            r_arg1   <= i_arg;
            r_acc_a1 <= i_acc_a;
            r_acc_b1 <= i_acc_b;
            r_p2     <= 62'(r_p1[59:30]) * 62'(M);
            r_arg2   <= r_arg1;
            r_acc_a2 <= r_acc_a1;
            r_acc_b2 <= r_acc_b1;
        end
    end

    assign w_term   = 31'(r_p2 >> SH);
    assign w_term_s = t_acc'({2'b00, w_term});
    assign o_term   = w_term;
    assign o_arg    = r_arg2;

    // accumulate the new term where this order contributes
    always_comb begin
        unique case (A_OP)
            OP_ADD:  o_acc_a = r_acc_a2 + w_term_s;
            OP_SUB:  o_acc_a = r_acc_a2 - w_term_s;
            default: o_acc_a = r_acc_a2;
        endcase
        unique case (B_OP)
            OP_ADD:  o_acc_b = r_acc_b2 + w_term_s;
            OP_SUB:  o_acc_b = r_acc_b2 - w_term_s;
            default: o_acc_b = r_acc_b2;
        endcase
    end

endmodule

// ===== rtl/core/pt_eta_phi_to_four_momentum_top.sv =====
// Top level: massless (pT, eta, phi) to (E, px, py, pz), fully pipelined.
//
//   channel | direction | handshake           | words
//   input   | in        | i_valid / o_ready   | transverse_momentum, pseudorapidity, azimuth
//   output  | out       | o_valid / i_ready   | energy, momentum_x, momentum_y, momentum_z
//
// One word accepted per cycle while the output is not stalled; the pipeline consists of
// the 16-cell exp chain (two registers per cell) plus three entry and four exit stages.
// The sin/cos chain has 14 cells and is delayed to line up with the exp chain.
// Reset clears the valid pipeline only.
// A stalled output word holds the whole pipeline; o_ready = !o_valid | i_ready.
module pt_eta_phi_to_four_momentum_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [15:0]        i_transverse_momentum,
    input  logic signed [15:0] i_pseudorapidity,
    input  logic signed [15:0] i_azimuth,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [26:0]        o_energy,
    output logic signed [16:0] o_momentum_x,
    output logic signed [16:0] o_momentum_y,
    output logic signed [27:0] o_momentum_z
);
    import pt4m_pkg::*;

    localparam int NSTG = 3 + 2 * EXP_TERMS + 4;

    logic            w_en;
    logic [NSTG-1:0] r_vld;

    // entry stages
    logic [15:0] r0_pt;
    logic [15:0] r0_eta;
    logic [15:0] r0_phi;
    logic [45:0] r1_tprod;
    logic [33:0] r1_x;
    logic [3:0]  r1_n;
    t_side       r1_side;
    logic [29:0] r2_t;
    logic [29:0] r2_r;
    t_side       r2_side;

    logic [13:0] w_u;
    logic        w_swap;
    logic [13:0] w_v;
    logic        w_neg;
    logic [15:0] w_a;
    logic [33:0] w_x;
    logic [3:0]  w_n;
    logic [35:0] w_nl;

    // chains
    logic [30:0] w_tt_term [TRIG_TERMS+1];
    logic [29:0] w_tt_arg  [TRIG_TERMS+1];
    t_acc        w_tt_a    [TRIG_TERMS+1];
    t_acc        w_tt_b    [TRIG_TERMS+1];
    logic [30:0] w_ex_term [EXP_TERMS+1];
    logic [29:0] w_ex_arg  [EXP_TERMS+1];
    t_acc        w_ex_a    [EXP_TERMS+1];
    t_acc        w_ex_b    [EXP_TERMS+1];

    logic [65:0] w_trig_d;
    t_acc        w_s0;
    t_acc        w_c0;
    t_side       w_side;

    // exit stages
    t_acc        r4_cx;
    t_acc        r4_sy;
    logic [42:0] r4_big;
    logic [31:0] r4_emr;
    t_side       r4_side;
    logic [47:0] r5_px_p;
    logic [47:0] r5_py_p;
    logic        r5_px_neg;
    logic        r5_py_neg;
    logic [42:0] r5_c2;
    logic [42:0] r5_s2;
    t_side       r5_side;
    logic [47:0] r6_px_p;
    logic [47:0] r6_py_p;
    logic        r6_px_neg;
    logic        r6_py_neg;
    logic [58:0] r6_e_p;
    logic [58:0] r6_z_p;
    logic        r6_neg;
    logic [26:0]        r_energy;
    logic signed [16:0] r_px;
    logic signed [16:0] r_py;
    logic signed [27:0] r_pz;

    t_acc        w_s;
    t_acc        w_c;
    t_acc        w_cx;
    t_acc        w_sy;
    logic [31:0] w_em;
    logic [32:0] w_half;
    logic [31:0] w_px_mag;
    logic [31:0] w_py_mag;
    logic [16:0] w_px_r;
    logic [16:0] w_py_r;
    logic [26:0] w_e_r;
    logic [26:0] w_z_r;

    // global advance: the pipeline moves unless the output word is held
    assign w_en    = ~r_vld[NSTG-1] | i_ready;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    // angle and eta reduction
    always_comb begin
        w_u    = r0_phi[13:0];
        w_swap = w_u > 14'd8192;
        w_v    = w_swap ? 14'(15'd16384 - 15'(w_u)) : w_u;
        w_neg  = r0_eta[15];
        w_a    = w_neg ? 16'(-r0_eta) : r0_eta;
        w_x    = {w_a, 18'd0};
        w_n    = '0;
        for (int k = 1; k <= N_MAX; k++) begin
            if (36'(w_x) >= ln2_mult(4'(k))) begin
                w_n = 4'(k);
            end
        end
        w_nl   = ln2_mult(r1_n);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_pt        <= i_transverse_momentum;
            r0_eta       <= i_pseudorapidity;
            r0_phi       <= i_azimuth;
            r1_tprod     <= 46'(w_v) * 46'(PI_Q30);
            r1_x         <= w_x;
            r1_n         <= w_n;
            r1_side.pt   <= r0_pt;
            r1_side.quad <= r0_phi[15:14];
            r1_side.swap <= w_swap;
            r1_side.neg  <= w_neg;
            r1_side.n    <= w_n;
            r2_t         <= 30'((r1_tprod + 46'd16384) >> 15);
            r2_r         <= 30'(36'(r1_x) - w_nl);
            r2_side      <= r1_side;
        end
    end

    // sin/cos chain: ss in a, cc in b
    assign w_tt_term[0] = Q_ONE;
    assign w_tt_arg[0]  = r2_t;
    assign w_tt_a[0]    = '0;
    assign w_tt_b[0]    = t_acc'({2'b00, Q_ONE});

    for (genvar k = 1; k <= TRIG_TERMS; k++) begin : g_trig
        localparam int TA = (k % 4 == 1) ? OP_ADD : ((k % 4 == 3) ? OP_SUB : OP_NONE);
        localparam int TB = (k % 4 == 2) ? OP_SUB : ((k % 4 == 0) ? OP_ADD : OP_NONE);
        pt4m_series_cell #(.K(k), .A_OP(TA), .B_OP(TB)) u_cell (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_term  (w_tt_term[k-1]),
            .i_arg   (w_tt_arg[k-1]),
            .i_acc_a (w_tt_a[k-1]),
            .i_acc_b (w_tt_b[k-1]),
            .o_term  (w_tt_term[k]),
            .o_arg   (w_tt_arg[k]),
            .o_acc_a (w_tt_a[k]),
            .o_acc_b (w_tt_b[k])
        );
    end

    // e^r in a, e^-r in b
    assign w_ex_term[0] = Q_ONE;
    assign w_ex_arg[0]  = r2_r;
    assign w_ex_a[0]    = t_acc'({2'b00, Q_ONE});
    assign w_ex_b[0]    = t_acc'({2'b00, Q_ONE});

    for (genvar k = 1; k <= EXP_TERMS; k++) begin : g_exp
        localparam int EB = (k % 2 == 1) ? OP_SUB : OP_ADD;
        pt4m_series_cell #(.K(k), .A_OP(OP_ADD), .B_OP(EB)) u_cell (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_term  (w_ex_term[k-1]),
            .i_arg   (w_ex_arg[k-1]),
            .i_acc_a (w_ex_a[k-1]),
            .i_acc_b (w_ex_b[k-1]),
            .o_term  (w_ex_term[k]),
            .o_arg   (w_ex_arg[k]),
            .o_acc_a (w_ex_a[k]),
            .o_acc_b (w_ex_b[k])
        );
    end

    // line up the shorter chain and the side data with the exp chain output
    pt4m_delay #(.W(66), .DEPTH(2 * (EXP_TERMS - TRIG_TERMS))) u_trig_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({w_tt_a[TRIG_TERMS], w_tt_b[TRIG_TERMS]}),
        .o_q   (w_trig_d)
    );

    pt4m_delay #(.W($bits(t_side)), .DEPTH(2 * EXP_TERMS)) u_side_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r2_side),
        .o_q   (w_side)
    );

    assign w_s0 = t_acc'(w_trig_d[65:33]);
    assign w_c0 = t_acc'(w_trig_d[32:0]);

    // quadrant mapping and hyperbolic combine
    always_comb begin
        w_s = w_side.swap ? w_c0 : w_s0;
        w_c = w_side.swap ? w_s0 : w_c0;
        unique case (w_side.quad)
            2'd0: begin
                w_cx = w_c;
                w_sy = w_s;
            end
            2'd1: begin
                w_cx = -w_s;
                w_sy = w_c;
            end
            2'd2: begin
                w_cx = -w_c;
                w_sy = -w_s;
            end
            default: begin
                w_cx = w_s;
                w_sy = -w_c;
            end
        endcase
        w_em   = (w_ex_b[EXP_TERMS] > 0) ? w_ex_b[EXP_TERMS][31:0] : 32'd0;
        w_half = 33'((34'd1 << w_side.n) >> 1);
        w_px_mag = r4_cx[32] ? 32'(-r4_cx) : r4_cx[31:0];
        w_py_mag = r4_sy[32] ? 32'(-r4_sy) : r4_sy[31:0];
        w_px_r = 17'((r6_px_p + 48'h2000_0000) >> FRAC_BITS);
        w_py_r = 17'((r6_py_p + 48'h2000_0000) >> FRAC_BITS);
        w_e_r  = 27'((r6_e_p + 59'h4000_0000) >> (FRAC_BITS + 1));
        w_z_r  = 27'((r6_z_p + 59'h4000_0000) >> (FRAC_BITS + 1));
    end

    // exit stages: products and rounding
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_cx     <= w_cx;
            r4_sy     <= w_sy;
            r4_big    <= 43'(w_ex_a[EXP_TERMS][31:0]) << w_side.n;
            r4_emr    <= 32'((33'(w_em) + w_half) >> w_side.n);
            r4_side   <= w_side;
            r5_px_p   <= 48'(r4_side.pt) * 48'(w_px_mag);
            r5_py_p   <= 48'(r4_side.pt) * 48'(w_py_mag);
            r5_px_neg <= r4_cx[32];
            r5_py_neg <= r4_sy[32];
            r5_c2     <= r4_big + 43'(r4_emr);
            r5_s2     <= r4_big - 43'(r4_emr);
            r5_side   <= r4_side;
            r6_px_p   <= r5_px_p;
            r6_py_p   <= r5_py_p;
            r6_px_neg <= r5_px_neg;
            r6_py_neg <= r5_py_neg;
            r6_e_p    <= 59'(r5_side.pt) * 59'(r5_c2);
            r6_z_p    <= 59'(r5_side.pt) * 59'(r5_s2);
            r6_neg    <= r5_side.neg;
            r_energy  <= w_e_r;
            r_px      <= r6_px_neg ? -$signed(w_px_r) : $signed(w_px_r);
            r_py      <= r6_py_neg ? -$signed(w_py_r) : $signed(w_py_r);
            r_pz      <= r6_neg ? -$signed({1'b0, w_z_r}) : $signed({1'b0, w_z_r});
        end
    end

    assign o_valid      = r_vld[NSTG-1];
    assign o_energy     = r_energy;
    assign o_momentum_x = r_px;
    assign o_momentum_y = r_py;
    assign o_momentum_z = r_pz;

    // |pz| for the energy bound check
    logic [27:0] w_zabs;
    assign w_zabs = o_momentum_z[27] ? 28'(-o_momentum_z) : 28'(o_momentum_z);

`ifndef ASSERT_OFF
    // a massless particle never has |pz| above E
    a_e_ge_pz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_energy} >= w_zabs))
        else $error("energy below |pz|");

    // reset empties the pipeline
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid word after reset");

    // a held output word freezes the valid pipeline
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(r_vld))
        else $error("pipeline moved during stall");
`endif

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the pT/eta/phi to four-momentum pipeline.
`timescale 1ns / 1ps

module testbench;

    localparam int  N_RANDOM    = 700;
    localparam int  DRAIN_WAIT  = 60;
    localparam int  CYCLE_LIMIT = 200000;
    localparam int  HOLD_CYCLES = 120;
    localparam logic [63:0] PI_Q = 64'd3373259426;
    localparam logic [63:0] LN2_Q = 64'd744261118;
    localparam logic [63:0] ONE_Q = 64'd1 << 30;

    typedef struct packed {
        logic [15:0] pt;
        logic [15:0] eta;
        logic [15:0] phi;
    } t_particle;

    typedef struct packed {
        logic [26:0] e;
        logic [16:0] px;
        logic [16:0] py;
        logic [27:0] pz;
    } t_fourvec;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [15:0] i_transverse_momentum = '0;
    logic signed [15:0] i_pseudorapidity = '0;
    logic signed [15:0] i_azimuth = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [26:0] o_energy;
    logic signed [16:0] o_momentum_x;
    logic signed [16:0] o_momentum_y;
    logic signed [27:0] o_momentum_z;

    t_particle particle_q[$];
    t_fourvec  momentum_q[$];
    int  n_errors = 0;
    int  n_checked = 0;
    int  n_sent = 0;
    int  cycle = 0;
    bit  stim_done = 0;
    bit  quiet = 0;
    bit  hold_req = 0;
    int  hold_left = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    logic o_ready_seen = 1'b0;

    pt_eta_phi_to_four_momentum_top u_top (.*);

    always #1 i_clk = ~i_clk;

    // scale by a Q30 fraction, halves away from zero
    function automatic logic signed [63:0] scale_q30(logic [63:0] pt, logic signed [63:0] f);
        logic [63:0] mag;
        logic [63:0] v;
        mag = (f < 0) ? 64'(-f) : 64'(f);
        v = (pt * mag + (64'd1 << 29)) >> 30;
        return (f < 0) ? -$signed(v) : $signed(v);
    endfunction

    // four-momentum of one massless particle
    function automatic t_fourvec four_momentum(t_particle p);
        t_fourvec r;
        logic [1:0]  quad;
        logic [63:0] u, v, t, term, a, x, n, rr, ep, em, emr, big, c2, s2, zmag;
        logic signed [63:0] ss, cc, s, c, cx, sy, sm;
        bit swap, neg;
        int sh;
        quad = p.phi[15:14];
        u = 64'(p.phi[13:0]);
        swap = u > 8192;
        v = swap ? 64'd16384 - u : u;
        t = (v * PI_Q + (64'd1 << 14)) >> 15;
        ss = 0; cc = $signed(ONE_Q); term = ONE_Q;
        for (int k = 1; k <= 14; k++) begin
            term = ((term * t) >> 30) / 64'(k);
            unique case (k % 4)
                1: ss += $signed(term);
                2: cc -= $signed(term);
                3: ss -= $signed(term);
                default: cc += $signed(term);
            endcase
        end
        if (swap) begin s = cc; c = ss; end
        else begin s = ss; c = cc; end
        unique case (quad)
            2'd0: begin cx = c;  sy = s;  end
            2'd1: begin cx = -s; sy = c;  end
            2'd2: begin cx = -c; sy = -s; end
            default: begin cx = s; sy = -c; end
        endcase
        r.px = 17'(scale_q30(64'(p.pt), cx));
        r.py = 17'(scale_q30(64'(p.pt), sy));
        neg = p.eta[15];
        a = neg ? 64'd65536 - 64'(p.eta) : 64'(p.eta);
        x = a << 18;
        n = x / LN2_Q;
        rr = x - n * LN2_Q;
        ep = ONE_Q; sm = $signed(ONE_Q); term = ONE_Q;
        for (int k = 1; k <= 16; k++) begin
            term = ((term * rr) >> 30) / 64'(k);
            ep += term;
            if (k % 2) sm -= $signed(term);
            else sm += $signed(term);
        end
        em = (sm > 0) ? 64'(sm) : 64'd0;
        sh = int'(n[5:0]);
        emr = (em + ((64'd1 << sh) >> 1)) >> sh;
        big = ep << sh;
        c2 = big + emr;
        s2 = big - emr;
        r.e = 27'((64'(p.pt) * c2 + ONE_Q) >> 31);
        zmag = (64'(p.pt) * s2 + ONE_Q) >> 31;
        r.pz = neg ? 28'(-$signed(zmag)) : 28'(zmag);
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s at word %0d: got %h want %h", field, n_checked, got, want);
        n_errors++;
    endtask

    function automatic t_particle mk(logic [15:0] pt, logic [15:0] eta, logic [15:0] phi);
        t_particle p;
        p.pt = pt; p.eta = eta; p.phi = phi;
        return p;
    endfunction

    // stimulus list
    initial begin
        particle_q.push_back(mk(16'd0, 16'd0, 16'd0));
        particle_q.push_back(mk(16'hFFFF, 16'd0, 16'd0));
        particle_q.push_back(mk(16'hFFFF, 16'd0, 16'h8000));
        particle_q.push_back(mk(16'hFFFF, 16'h8000, 16'h4000));
        particle_q.push_back(mk(16'hFFFF, 16'h7FFF, 16'hC000));
        particle_q.push_back(mk(16'hFFFF, 16'h8000, 16'h7FFF));
        particle_q.push_back(mk(16'd1, 16'h7FFF, 16'h2000));
        particle_q.push_back(mk(16'd1234, 16'd1, 16'h2001));
        particle_q.push_back(mk(16'd1234, 16'hFFFF, 16'h1FFF));
        particle_q.push_back(mk(16'h8000, 16'd2839, 16'h6000));
        particle_q.push_back(mk(16'h8000, -16'sd2839, 16'hA000));
        particle_q.push_back(mk(16'h5555, 16'h5555, 16'h5555));
        particle_q.push_back(mk(16'hAAAA, 16'hAAAA, 16'hAAAA));
        particle_q.push_back(mk(16'd16, 16'd4096, 16'hFFFF));
        for (int i = 0; i < N_RANDOM; i++) begin
            t_particle p;
            p.pt = (i % 5 == 0) ? 16'($urandom_range(0, 63)) : 16'($urandom);
            p.eta = (i % 7 == 0) ? 16'($urandom_range(0, 8)) - 16'd4 : 16'($urandom);
            p.phi = 16'($urandom);
            particle_q.push_back(p);
        end
        stim_done = 1;
    end

    // reset, long receiver hold, end of run
    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        wait (n_sent > 200);
        hold_req = 1;
        wait (n_sent > 500);
        quiet = 1;
        wait (stim_done && particle_q.size() == 0 && !i_valid && momentum_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("sent %0d particles, checked %0d four-vectors, incl. a long output stall",
                 n_sent, n_checked);
        if (n_errors == 0 && momentum_q.size() == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle);
            $display("== FAIL ==");
            $finish;
        end
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || o_ready_seen) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (particle_q.size() > 0) begin
                    t_particle p;
                    p = particle_q.pop_front();
                    i_transverse_momentum <= p.pt;
                    i_pseudorapidity <= p.eta;
                    i_azimuth <= p.phi;
                    i_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 9);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // input acceptance seen at the rising edge
    always @(posedge i_clk) begin
        o_ready_seen <= i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            momentum_q.push_back(four_momentum(mk(i_transverse_momentum,
                                 i_pseudorapidity, i_azimuth)));
            n_sent <= n_sent + 1;
        end
    end

    // receiver ready, with random gaps and one long hold
    always @(negedge i_clk) begin
        if (hold_req && hold_left == 0) begin
            hold_left <= HOLD_CYCLES;
            hold_req <= 0;
            i_ready <= 1'b0;
        end else if (hold_left > 1) begin
            hold_left <= hold_left - 1;
        end else if (hold_left == 1) begin
            hold_left <= -1;
            i_ready <= 1'b1;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            i_ready <= (recv_gap == 1);
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(1, 9);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (momentum_q.size() == 0) begin
                $display("unexpected word at cycle %0d", cycle);
                n_errors++;
            end else begin
                t_fourvec w;
                w = momentum_q.pop_front();
                if (o_energy !== w.e) report_mismatch("energy", 32'(o_energy), 32'(w.e));
                if (o_momentum_x !== w.px)
                    report_mismatch("momentum_x", 32'(o_momentum_x), 32'(w.px));
                if (o_momentum_y !== w.py)
                    report_mismatch("momentum_y", 32'(o_momentum_y), 32'(w.py));
                if (o_momentum_z !== w.pz)
                    report_mismatch("momentum_z", 32'(o_momentum_z), 32'(w.pz));
                n_checked++;
            end
        end
    end

endmodule
